[src/point_segment_distance_3d_top_assert.svh]
// ----------------------------------------------------------------------------
// point_segment_distance_3d_top_assert.svh
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_3D_TOP_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_3D_TOP_ASSERT_SVH

// implication checked while out of reset
`define PSD3_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication, also checked across reset
`define PSD3_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

[src/psd3_pkg.sv]
// ----------------------------------------------------------------------------
// psd3_pkg
// widths and stage record types of the point to segment distance pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package psd3_pkg;

    localparam int COORD_W    = 32;            // input coordinate width
    localparam int DIFF_W     = COORD_W + 1;   // difference of two coordinates
    localparam int LEN_W      = 2 * DIFF_W + 1; // squared length of d
    localparam int DOT_W      = LEN_W + 1;     // signed dot product
    localparam int T_BITS     = 32;            // projection fraction bits
    localparam int PROD_W     = DIFF_W + T_BITS;
    localparam int RES_W      = DIFF_W + 2;    // residual component
    localparam int SQ_W       = 2 * RES_W + 2; // sum of three residual squares
    localparam int ROOT_W     = 35;            // square root steps
    localparam int DIST_W     = 34;
    localparam int IN_BYTES_W = 288;
    localparam int OUT_DATA_W = 40;

    // segment vector and query offset
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] d;
        logic [2:0][DIFF_W-1:0] w;
    } geo_t;

    // one step of the projection divider
    typedef struct packed {
        logic              vld;
        logic              degen;
        logic              pre_start;
        logic              past;
        geo_t              geo;
        logic [LEN_W-1:0]  len2;
        logic [LEN_W-1:0]  rem;
        logic [T_BITS-1:0] frac;
    } div_t;

    // one step of the square root
    typedef struct packed {
        logic              vld;
        logic              degen;
        logic [SQ_W-1:0]   val;
        logic [ROOT_W-1:0] root;
        logic [SQ_W-1:0]   sq;
    } root_t;

endpackage

`default_nettype wire

[src/point_segment_distance_3d_top.sv]
// ----------------------------------------------------------------------------
// point_segment_distance_3d_top
// euclidean distance from a query point to a 3d segment, fixed point
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_      | in  | start xyz, end xyz, query xyz (signed q16.16, 32b each)
//  m_      | out | distance (unsigned q18.16, 34b), degenerate flag in tuser
//
//  one transfer per cycle in each direction while m_ is not stalled
//  most of the latency comes from the 32 bit-steps of the projection divider and the
//  35 bit-steps of the square root, each a register stage
//  a stall on m_ freezes the whole pipeline; s_tready is low only while m_ holds a stalled result
//  aresetn clears the valid bits only
`default_nettype none

module point_segment_distance_3d_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, query_x, query_y, query_z
    input  wire logic [psd3_pkg::IN_BYTES_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // distance, zero pad
    output logic [psd3_pkg::OUT_DATA_W-1:0]    m_tdata,
    // degenerate
    output logic                               m_tuser
);
    import psd3_pkg::*;

    logic adv;

    // front stages
    logic v1_reg, v2_reg, v3_reg;
    geo_t g1_reg, g2_reg, g3_reg, g1_next;
    logic signed [2*DIFF_W-1:0] dd2_reg [3];
    logic signed [2*DIFF_W-1:0] wd2_reg [3];
    logic [LEN_W-1:0] len3_reg;
    logic signed [DOT_W-1:0] dot3_reg;

    div_t  div_reg [T_BITS+1];
    div_t  div0_next;
    root_t root_reg [ROOT_W+1];
    root_t root0_next;

    // scale and residual stages
    logic v5_reg, v6_reg, v7_reg;
    logic dg5_reg, bf5_reg, ps5_reg, dg6_reg, dg7_reg;
    geo_t g5_reg;
    logic [PROD_W-1:0] m5_reg [3];
    logic signed [RES_W-1:0] r6_reg [3];
    logic signed [RES_W-1:0] r6_next [3];
    logic [2*RES_W-1:0] s7_reg [3];

    // whole pipeline moves unless the output holds a stalled transfer
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 1: differences
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            g1_next.d[i] = DIFF_W'($signed(s_tdata[COORD_W*(3+i) +: COORD_W]))
                         - DIFF_W'($signed(s_tdata[COORD_W*i +: COORD_W]));
            g1_next.w[i] = DIFF_W'($signed(s_tdata[COORD_W*(6+i) +: COORD_W]))
                         - DIFF_W'($signed(s_tdata[COORD_W*i +: COORD_W]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stages 1 to 3: products, then sums
    always_ff @(posedge aclk) begin
        if (adv) begin
            g1_reg <= g1_next;
            g2_reg <= g1_reg;
            g3_reg <= g2_reg;
            for (int i = 0; i < 3; i++) begin
                dd2_reg[i] <= $signed(g1_reg.d[i]) * $signed(g1_reg.d[i]);
                wd2_reg[i] <= $signed(g1_reg.w[i]) * $signed(g1_reg.d[i]);
            end
            len3_reg <= LEN_W'(DOT_W'(dd2_reg[0]) + DOT_W'(dd2_reg[1])
                               + DOT_W'(dd2_reg[2]));
            dot3_reg <= DOT_W'(wd2_reg[0]) + DOT_W'(wd2_reg[1]) + DOT_W'(wd2_reg[2]);
        end
    end

    // stage 4: classify the projection
    always_comb begin
        div0_next.vld       = v3_reg;
        div0_next.degen     = (len3_reg == '0);
        div0_next.pre_start = (dot3_reg <= 0);
        div0_next.past      = !div0_next.pre_start && (dot3_reg[LEN_W-1:0] >= len3_reg);
        div0_next.geo       = g3_reg;
        div0_next.len2      = len3_reg;
        div0_next.rem       = (div0_next.pre_start || div0_next.past) ? '0
                                                                      : dot3_reg[LEN_W-1:0];
        div0_next.frac      = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg[0].vld <= 1'b0;
        end else if (adv) begin
            div_reg[0] <= div0_next;
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar k = 0; k < T_BITS; k++) begin : g_div
        logic [LEN_W:0] sh;
        logic           ge;
        div_t           nxt;

        always_comb begin
            sh       = {div_reg[k].rem, 1'b0};
            ge       = (sh >= {1'b0, div_reg[k].len2});
            nxt      = div_reg[k];
            nxt.rem  = ge ? LEN_W'(sh - {1'b0, div_reg[k].len2}) : sh[LEN_W-1:0];
            nxt.frac = {div_reg[k].frac[T_BITS-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_reg[k+1].vld <= 1'b0;
            end else if (adv) begin
                div_reg[k+1] <= nxt;
            end
        end
    end

    // stage 5: scale |d| by the fraction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else if (adv) begin
            v5_reg <= div_reg[T_BITS].vld;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dg5_reg <= div_reg[T_BITS].degen;
            bf5_reg <= div_reg[T_BITS].pre_start;
            ps5_reg <= div_reg[T_BITS].past;
            g5_reg  <= div_reg[T_BITS].geo;
            for (int i = 0; i < 3; i++) begin
                m5_reg[i] <= PROD_W'(div_reg[T_BITS].geo.d[i][DIFF_W-1]
                                     ? DIFF_W'(-div_reg[T_BITS].geo.d[i])
                                     : div_reg[T_BITS].geo.d[i])
                           * PROD_W'(div_reg[T_BITS].frac);
            end
        end
    end

    // stage 6: residual per case, projection floored toward minus infinity
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [RES_W-1:0] q;
            logic [RES_W-1:0] proj;
            q    = RES_W'(m5_reg[i][PROD_W-1:T_BITS]);
            proj = g5_reg.d[i][DIFF_W-1] ? RES_W'(-(q + RES_W'(|m5_reg[i][T_BITS-1:0])))
                                         : q;
            priority if (dg5_reg || bf5_reg) begin
                r6_next[i] = RES_W'($signed(g5_reg.w[i]));
            end else if (ps5_reg) begin
                r6_next[i] = RES_W'($signed(g5_reg.w[i])) - RES_W'($signed(g5_reg.d[i]));
            end else begin
                r6_next[i] = RES_W'($signed(g5_reg.w[i])) - $signed(proj);
            end
        end
    end

    // stages 6 and 7: residual, squares
    always_ff @(posedge aclk) begin
        if (adv) begin
            dg6_reg <= dg5_reg;
            dg7_reg <= dg6_reg;
            for (int i = 0; i < 3; i++) begin
                r6_reg[i] <= r6_next[i];
                s7_reg[i] <= (2*RES_W)'(r6_reg[i] * r6_reg[i]);
            end
        end
    end

    // stage 8: sum of squares enters the square root
    always_comb begin
        root0_next.vld   = v7_reg;
        root0_next.degen = dg7_reg;
        root0_next.val   = SQ_W'(s7_reg[0]) + SQ_W'(s7_reg[1]) + SQ_W'(s7_reg[2]);
        root0_next.root  = '0;
        root0_next.sq    = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg[0].vld <= 1'b0;
        end else if (adv) begin
            root_reg[0] <= root0_next;
        end
    end

    // square root, one result bit per stage, square kept alongside
    for (genvar j = 0; j < ROOT_W; j++) begin : g_root
        localparam int B = ROOT_W - 1 - j;
        logic [SQ_W:0] cand;
        root_t         nxt;

        always_comb begin
            cand = {1'b0, root_reg[j].sq}
                 + ((SQ_W+1)'(root_reg[j].root) << (B + 1))
                 + ((SQ_W+1)'(1) << (2 * B));
            nxt  = root_reg[j];
            if (cand <= {1'b0, root_reg[j].val}) begin
                nxt.root = root_reg[j].root | (ROOT_W'(1) << B);
                nxt.sq   = cand[SQ_W-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                root_reg[j+1].vld <= 1'b0;
            end else if (adv) begin
                root_reg[j+1] <= nxt;
            end
        end
    end

    // result channel
    assign m_tvalid = root_reg[ROOT_W].vld;
    assign m_tdata  = {(OUT_DATA_W - DIST_W)'(0), root_reg[ROOT_W].root[DIST_W-1:0]};
    assign m_tuser  = root_reg[ROOT_W].degen;

endmodule

`default_nettype wire

[src/psd3_checker.sv]
// ----------------------------------------------------------------------------
// psd3_checker
// port-level checks of the distance pipeline, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_segment_distance_3d_top_assert.svh"

module psd3_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser
);
    // a stalled result holds its value
    `PSD3_ASSERT_IMP(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, ##1 (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    // input side stalls exactly while a result is stalled
    `PSD3_ASSERT_IMP(a_ready_follow, aclk, aresetn, 1'b1, s_tready == (!m_tvalid || m_tready))
    // reset empties the pipeline
    `PSD3_ASSERT_NXT(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)
    // pad bits above the distance stay zero
    `PSD3_ASSERT_IMP(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[39:34] == 6'd0)

endmodule

bind point_segment_distance_3d_top psd3_checker u_psd3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
